// ===== rtl/piecewise_linear_curve_map_unit_defines.svh =====
// assertion macros of the curve map rtl
`ifndef PIECEWISE_LINEAR_CURVE_MAP_UNIT_DEFINES_SVH
`define PIECEWISE_LINEAR_CURVE_MAP_UNIT_DEFINES_SVH

// same-cycle implication, reset masked
`define PLCM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define PLCM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/plcm_pkg.sv =====
// types and constants of the piecewise linear curve map
package plcm_pkg;

	localparam int SEGMENTS_DEF   = 16;
	localparam int MAX_DEPTH_DEF  = 12;
	localparam int CUM_W          = 21;
	localparam logic [15:0] LAST_KNOT_MARK  = 16'h0f00;
	localparam logic [15:0] LAST_KNOT_VALUE = 16'h1000;

	typedef enum logic [1:0] {
		OP_KNOT  = 2'd0,
		OP_DEPTH = 2'd1,
		OP_MAP   = 2'd2
	} op_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [4:0]  entry;
		logic [15:0] knot_value;
		logic [3:0]  seg_depth;
		logic [15:0] lumi_in;
	} in_word_t;

	typedef struct packed {
		logic [15:0] lumi_out;
		logic        beyond_curve;
	} out_word_t;

	typedef struct packed {
		logic        knot_we;
		logic        depth_we;
		logic [15:0] knot;
		logic [3:0]  depth;
	} cell_wr_t;

	typedef struct packed {
		logic             valid;
		logic             found;
		logic [15:0]      x;
		logic [CUM_W-1:0] cum;
		logic [15:0]      w;
		logic [3:0]       d;
		logic [15:0]      ka;
		logic [15:0]      kb;
	} token_t;

endpackage

// ===== rtl/plcm_chan_if.sv =====
// valid/ready channel carrying one word
interface plcm_chan_if #(parameter type word_t = logic) ();
	logic  valid;
	logic  ready;
	word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/plcm_cell.sv =====
// one segment cell: holds knot and depth, advances the search token
module plcm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  plcm_pkg::cell_wr_t wr,
	input  logic [15:0]        next_knot,
	input  plcm_pkg::token_t   tok_in,
	output plcm_pkg::token_t   tok_out,
	output logic [15:0]        knot
);
	logic [15:0] knot_q;
	logic [3:0]  depth_q;
	logic        valid_q;
	plcm_pkg::token_t tok_q;
	plcm_pkg::token_t tok_d;
	logic [plcm_pkg::CUM_W-1:0] cum_n;
	logic        hit;

	always_ff @(posedge clk) begin
		if (wr.knot_we) begin
			knot_q <= wr.knot;
		end
		if (wr.depth_we) begin
			depth_q <= wr.depth;
		end
	end

	always_comb begin
		cum_n = tok_in.cum + (plcm_pkg::CUM_W'(1) << depth_q);
		hit   = !tok_in.found && (plcm_pkg::CUM_W'(tok_in.x) < cum_n);
		tok_d = tok_in;
		if (!tok_in.found) begin
			tok_d.cum = cum_n;
		end
		if (hit) begin
			tok_d.found = 1'b1;
			tok_d.w     = 16'(cum_n - plcm_pkg::CUM_W'(tok_in.x));
			tok_d.d     = depth_q;
			tok_d.ka    = knot_q;
			tok_d.kb    = next_knot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_d;
	end

	always_comb begin
		tok_out       = tok_q;
		tok_out.valid = valid_q;
	end

	assign knot = knot_q;
endmodule

// ===== rtl/plcm_interp.sv =====
// interpolation between the two knots of the found segment, or a zero beyond-curve result if none was found
module plcm_interp (
	input  logic                clk,
	input  logic                arst_n,
	input  plcm_pkg::token_t    tok,
	input  logic                take,
	output logic                res_valid,
	output plcm_pkg::out_word_t res
);
	logic        valid_s1;
	logic        found_s1;
	logic [31:0] p0_s1;
	logic [31:0] p1_s1;
	logic [3:0]  d_s1;
	logic        valid_s2;
	plcm_pkg::out_word_t res_s2;
	logic [15:0] span;
	logic [31:0] acc;
	logic [31:0] shifted;

	assign span = 16'(1) << tok.d;

	always_ff @(posedge clk) begin
		if (tok.valid) begin
			found_s1 <= tok.found;
			p0_s1    <= 32'(tok.w) * 32'(tok.ka);
			p1_s1    <= 32'(16'(span - tok.w)) * 32'(tok.kb);
			d_s1     <= tok.d;
		end
	end

	assign acc     = p0_s1 + p1_s1;
	assign shifted = acc >> d_s1;

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			if (found_s1) begin
				res_s2.lumi_out     <= {shifted[15:2], 2'b00};
				res_s2.beyond_curve <= 1'b0;
			end else begin
				res_s2.lumi_out     <= '0;
				res_s2.beyond_curve <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= tok.valid;
			if (valid_s1) begin
				valid_s2 <= 1'b1;
			end else if (take) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;
endmodule

// ===== rtl/piecewise_linear_curve_map_unit.sv =====
// top level of the piecewise linear luminance curve map
// A load word (knot or depth) is written when it is taken. A map word walks a chain of
// SEGMENTS cells, one cell per cycle, then two interpolation stages, and lands in
// the output register; the unit takes one map word at a time, and no word of any
// kind while a map word is in flight. A finished result may wait in the output
// register while the next word is taken. Tables are not cleared at reset.
`include "piecewise_linear_curve_map_unit_defines.svh"

module piecewise_linear_curve_map_unit #(
	parameter int SEGMENTS  = plcm_pkg::SEGMENTS_DEF,
	parameter int MAX_DEPTH = plcm_pkg::MAX_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	plcm_chan_if.sink   in_words,
	plcm_chan_if.source out_words
);
	plcm_pkg::in_word_t  iw;
	plcm_pkg::token_t    tok [0:SEGMENTS];
	plcm_pkg::cell_wr_t  wr [0:SEGMENTS-1];
	logic [15:0]         knots [0:SEGMENTS-1];
	logic [15:0]         last_knot_q;
	logic                busy_q;
	logic                accept;
	logic                is_knot;
	logic                is_depth;
	logic                is_map;
	logic [3:0]          depth_sat;
	logic [15:0]         knot_last_val;
	logic                res_valid;
	plcm_pkg::out_word_t res;
	logic                take;
	logic                out_valid_q;
	plcm_pkg::out_word_t out_q;
	logic [SEGMENTS:0]   chain_vec;

	assign iw       = in_words.data;
	assign accept   = in_words.valid && in_words.ready;
	assign is_knot  = iw.op == plcm_pkg::OP_KNOT;
	assign is_depth = iw.op == plcm_pkg::OP_DEPTH;
	assign is_map   = iw.op == plcm_pkg::OP_MAP;
	assign in_words.ready = !busy_q;

	assign depth_sat = (iw.seg_depth > 4'(MAX_DEPTH)) ? 4'(MAX_DEPTH) : iw.seg_depth;
	assign knot_last_val = ((iw.knot_value & plcm_pkg::LAST_KNOT_MARK) == plcm_pkg::LAST_KNOT_MARK)
		? plcm_pkg::LAST_KNOT_VALUE : iw.knot_value;

	// search token entering the first cell
	always_comb begin
		tok[0]       = '0;
		tok[0].valid = accept && is_map;
		tok[0].x     = iw.lumi_in;
	end

	for (genvar i = 0; i < SEGMENTS; i++) begin : g_cell
		assign wr[i].knot_we  = accept && is_knot && (6'(iw.entry) == 6'(i));
		assign wr[i].depth_we = accept && is_depth && (6'(iw.entry) == 6'(i));
		assign wr[i].knot     = iw.knot_value;
		assign wr[i].depth    = depth_sat;

		if (i == SEGMENTS - 1) begin : g_last
			plcm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.wr        (wr[i]),
				.next_knot (last_knot_q),
				.tok_in    (tok[i]),
				.tok_out   (tok[i+1]),
				.knot      (knots[i])
			);
		end else begin : g_mid
			plcm_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.wr        (wr[i]),
				.next_knot (knots[i+1]),
				.tok_in    (tok[i]),
				.tok_out   (tok[i+1]),
				.knot      (knots[i])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_knot && (6'(iw.entry) == 6'(SEGMENTS))) begin
			last_knot_q <= knot_last_val;
		end
	end

	plcm_interp u_interp (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok       (tok[SEGMENTS]),
		.take      (take),
		.res_valid (res_valid),
		.res       (res)
	);

	assign take = res_valid && (!out_valid_q || out_words.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept && is_map) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
			if (take) begin
				out_valid_q <= 1'b1;
			end else if (out_words.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= res;
		end
	end

	assign out_words.valid = out_valid_q;
	assign out_words.data  = out_q;

	// in-flight map words across the cell chain and the interpolation output
	always_comb begin
		for (int k = 0; k < SEGMENTS; k++) begin
			chain_vec[k] = tok[k+1].valid;
		end
		chain_vec[SEGMENTS] = res_valid;
	end

	`PLCM_ASSERT_NEXT(a_map_sets_busy, accept && is_map, busy_q, "map word taken but unit not busy")
	`PLCM_ASSERT_NOW(a_single_word, 1'b1, $onehot0(chain_vec), "more than one map word in flight")
	`PLCM_ASSERT_NOW(a_flight_busy, chain_vec != '0, busy_q, "map word in flight while idle")
	`PLCM_ASSERT_NOW(a_beyond_zero, out_valid_q && out_q.beyond_curve, out_q.lumi_out == 16'd0, "beyond curve with nonzero output")
endmodule

// ===== tb/piecewise_linear_curve_map_unit_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the piecewise linear curve map unit with a scoreboard class
module piecewise_linear_curve_map_unit_tb;

	localparam int SEG          = plcm_pkg::SEGMENTS_DEF;
	localparam int MAXD         = plcm_pkg::MAX_DEPTH_DEF;
	localparam int ITEMS        = 1600;
	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 2 * SEG + 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef enum int {
		CURVE_ANY,
		CURVE_SHORT,
		CURVE_FULL,
		CURVE_WIDE
	} curve_shape_t;

	class curve_map_scoreboard;
		logic [15:0] knots [SEG + 1];
		logic [3:0]  depths [SEG];
		plcm_pkg::out_word_t expected_maps [$];
		int          mismatches;

		task report(string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at %0t: %s", $time, msg);
		endtask

		function void note_word(plcm_pkg::in_word_t w);
			int unsigned cum, span, wgt, acc;
			bit found;
			plcm_pkg::out_word_t r;
			cum = 0;
			found = 1'b0;
			r.lumi_out = '0;
			r.beyond_curve = 1'b1;
			case (plcm_pkg::op_t'(w.op))
				plcm_pkg::OP_KNOT: begin
					if (w.entry <= SEG) begin
						if (w.entry == SEG && (w.knot_value & plcm_pkg::LAST_KNOT_MARK)
							== plcm_pkg::LAST_KNOT_MARK)
							knots[w.entry] = plcm_pkg::LAST_KNOT_VALUE;
						else
							knots[w.entry] = w.knot_value;
					end
				end
				plcm_pkg::OP_DEPTH: begin
					if (w.entry < SEG)
						depths[w.entry] = (w.seg_depth > MAXD) ? 4'(MAXD) : w.seg_depth;
				end
				plcm_pkg::OP_MAP: begin
					for (int i = 0; i < SEG; i++) begin
						span = 1 << depths[i];
						cum += span;
						if (!found && w.lumi_in < cum) begin
							found = 1'b1;
							wgt = cum - w.lumi_in;
							acc = wgt * knots[i] + (span - wgt) * knots[i + 1];
							r.lumi_out = 16'(acc >> depths[i]) & 16'hfffc;
							r.beyond_curve = 1'b0;
						end
					end
					expected_maps.push_back(r);
				end
				default: ;
			endcase
		endfunction

		task check_word(plcm_pkg::out_word_t got);
			plcm_pkg::out_word_t want;
			if (expected_maps.size() == 0) begin
				report($sformatf("result word %h with none expected", got));
			end else begin
				want = expected_maps.pop_front();
				if (got.lumi_out !== want.lumi_out)
					report($sformatf("lumi_out %h, expected %h", got.lumi_out, want.lumi_out));
				if (got.beyond_curve !== want.beyond_curve)
					report($sformatf("beyond_curve %b, expected %b",
						got.beyond_curve, want.beyond_curve));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int idle_cycles = 0;
	curve_map_scoreboard sb;

	plcm_chan_if #(.word_t(plcm_pkg::in_word_t))  in_ch ();
	plcm_chan_if #(.word_t(plcm_pkg::out_word_t)) out_ch ();

	piecewise_linear_curve_map_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_words (in_ch),
		.out_words(out_ch)
	);

	always #2 clk = ~clk;

	// receiver, with one long hold-off so the unit backs up
	always @(posedge clk) begin
		if (hold_request && !hold_done) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready)
				sb.check_word(out_ch.data);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic plcm_pkg::in_word_t noise_word();
		plcm_pkg::in_word_t w;
		w.op = 2'($urandom);
		w.entry = 5'($urandom);
		w.knot_value = 16'($urandom);
		w.seg_depth = 4'($urandom);
		w.lumi_in = 16'($urandom);
		return w;
	endfunction

	function automatic int unsigned curve_end(int k);
		int unsigned cum = 0;
		for (int i = 0; i <= k; i++)
			cum += 1 << sb.depths[i];
		return cum;
	endfunction

	function automatic logic [15:0] pick_lumi();
		int unsigned total, e;
		total = curve_end(SEG - 1);
		case ($urandom_range(4))
			0, 1: return 16'($urandom);
			2, 3: return (total > 65536) ? 16'($urandom) : 16'($urandom_range(total - 1));
			default: begin
				e = curve_end($urandom_range(SEG - 1)) + $urandom_range(2) - 1;
				return (e > 65535) ? 16'hffff : e[15:0];
			end
		endcase
	endfunction

	task automatic send_word(input plcm_pkg::in_word_t w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= w;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_word(w);
	endtask

	task automatic load_knot(input int e, input logic [15:0] v);
		plcm_pkg::in_word_t w;
		w = noise_word();
		w.op = plcm_pkg::OP_KNOT;
		w.entry = 5'(e);
		w.knot_value = v;
		send_word(w);
	endtask

	task automatic load_depth(input int e, input logic [3:0] d);
		plcm_pkg::in_word_t w;
		w = noise_word();
		w.op = plcm_pkg::OP_DEPTH;
		w.entry = 5'(e);
		w.seg_depth = d;
		send_word(w);
	endtask

	task automatic map_lumi(input logic [15:0] x);
		plcm_pkg::in_word_t w;
		w = noise_word();
		w.op = plcm_pkg::OP_MAP;
		w.lumi_in = x;
		send_word(w);
	endtask

	task automatic unused_op();
		plcm_pkg::in_word_t w;
		w = noise_word();
		w.op = OP_UNUSED;
		send_word(w);
	endtask

	task automatic load_curve(input curve_shape_t shape);
		logic [3:0] d;
		for (int i = 0; i < SEG; i++) begin
			case (shape)
				CURVE_ANY:   d = 4'($urandom);
				CURVE_SHORT: d = 4'($urandom_range(6));
				CURVE_FULL:  d = 4'd12 + 4'($urandom_range(3));
				default:     d = 4'($urandom_range(12, 9));
			endcase
			load_depth(i, d);
		end
		for (int i = 0; i <= SEG; i++)
			load_knot(i, 16'($urandom));
	endtask

	task automatic random_word(output bit counted);
		int r;
		int e;
		logic [15:0] kv;
		r = $urandom_range(99);
		counted = 1'b1;
		kv = 16'($urandom);
		if ($urandom_range(3) == 0)
			kv = kv | plcm_pkg::LAST_KNOT_MARK;
		e = ($urandom_range(3) == 0) ? SEG : $urandom_range(SEG);
		if (r < 55)
			map_lumi(pick_lumi());
		else if (r < 70)
			load_knot(e, kv);
		else if (r < 82)
			load_depth($urandom_range(SEG - 1), 4'($urandom));
		else if (r < 88)
			load_knot($urandom_range(31, SEG + 1), kv);
		else if (r < 94)
			load_depth($urandom_range(31, SEG), 4'($urandom));
		else begin
			unused_op();
			counted = 1'b0;
		end
	endtask

	initial begin
		int done;
		bit counted;
		sb = new();
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill both tables before any lookup
		for (int i = 0; i < SEG; i++)
			load_depth(i, 4'((i < 12) ? i : 12));
		load_knot(0, 16'h0000);
		load_knot(1, 16'hffff);
		for (int i = 2; i < SEG; i++)
			load_knot(i, 16'($urandom));
		load_knot(SEG, 16'h2f5a);

		// out-of-range writes, depth saturation, unused op, curve edges, last-knot marker
		load_knot(SEG + 1, 16'h1234);
		load_knot(31, 16'hffff);
		load_depth(SEG, 4'd3);
		load_depth(31, 4'd15);
		load_depth(SEG - 1, 4'd15);
		unused_op();
		map_lumi(16'h0000);
		map_lumi(16'h0001);
		map_lumi(16'hffff);
		map_lumi(16'(curve_end(5) - 1));
		map_lumi(16'(curve_end(5)));
		map_lumi(16'(curve_end(SEG - 1) - 1));
		map_lumi(16'(curve_end(SEG - 1)));
		load_knot(SEG, 16'hffff);
		map_lumi(16'(curve_end(SEG - 1) - 1));
		load_knot(SEG, 16'h0eff);
		map_lumi(16'(curve_end(SEG - 1) - 1));
		map_lumi(16'(curve_end(SEG - 1) - 2));

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 48 : 0;
			recv_idle_pct = (phase == 0) ? 48 : (phase == 1) ? 25 : 0;
			if (phase == 2)
				hold_request = 1'b1;
			done = 0;
			while (done < ITEMS / 3) begin
				if ($urandom_range(99) < 3) begin
					load_curve(curve_shape_t'($urandom_range(3)));
					done += 2 * SEG + 1;
				end else begin
					random_word(counted);
					if (counted)
						done++;
				end
			end
		end
		in_ch.valid <= 1'b0;

		while (sb.expected_maps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_maps.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/plcm_pkg.sv
rtl/plcm_chan_if.sv
rtl/plcm_cell.sv
rtl/plcm_interp.sv
rtl/piecewise_linear_curve_map_unit.sv
tb/piecewise_linear_curve_map_unit_tb.sv
